@@ hdl/lpm_pkg.sv @@
// Package with types, constants and helpers shared by the forwarding engine.
`timescale 1ns / 1ps
`default_nettype none
package lpm_pkg;

   localparam int unsigned TrieNodesDefault = 1024;
   localparam int unsigned MaxPrefix = 32;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      ACT_LOCAL    = 3'd0,
      ACT_FORWARD  = 3'd1,
      ACT_NO_ROUTE = 3'd2,
      ACT_TTL_DROP = 3'd3,
      ACT_ADDED    = 3'd4,
      ACT_FULL     = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_STEP,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic        func;
      logic [31:0] route_prefix;
      logic [5:0]  prefix_len;
      logic [31:0] route_next_hop;
      logic [31:0] packet_dst;
      logic [7:0]  packet_ttl;
      logic [15:0] packet_checksum;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] next_hop;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
   } rsp_type;

   // Classified job handed from the front part to the trie walker.
   typedef struct packed {
      logic        is_insert;
      logic        is_local;
      logic [31:0] key;
      logic [5:0]  depth;
      logic [31:0] hop;
      logic [7:0]  ttl;
      logic [15:0] checksum;
   } job_type;

   function automatic logic [15:0] csum_update(input logic [15:0] cks, input logic [7:0] ttl,
                                               input logic [7:0] ttl_new);
      logic [17:0] s;
      logic [16:0] f;
      logic [16:0] g;
      s = {2'b00, ~cks} + {2'b00, ~{ttl, 8'h00}} + {2'b00, ttl_new, 8'h00};
      f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      g = {1'b0, f[15:0]} + {16'd0, f[16]};
      return ~g[15:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/ipv4_lpm_forwarding_engine_unit.sv @@
// Top level of the IPv4 longest-prefix-match forwarding engine.
`timescale 1ns / 1ps
`default_nettype none
// Items enter a two-entry job queue where local delivery is decided at once; a
// walker then reads the trie node memory one level at a time (registered read in
// WAIT, then step in STEP). A local delivery goes straight to DONE with no walk;
// a level reached by allocating a new node skips the registered read (STEP to STEP).
// Results wait in an output register, so the next item is taken meanwhile.
module ipv4_lpm_forwarding_engine_unit #(
   parameter int unsigned TRIE_NODES = lpm_pkg::TrieNodesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire lpm_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output lpm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [31:0]      csr_wdata
);
   logic [31:0]      local_addr_ff;
   logic             job_valid, job_take;
   lpm_pkg::job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_we) begin
         local_addr_ff <= csr_wdata;
      end
   end

   lpm_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .req_data(req_data), .local_address(local_addr_ff),
      .job_valid(job_valid), .job_take(job_take), .job(job));

   lpm_walker #(.TRIE_NODES(TRIE_NODES)) u_walker (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_take(job_take),
      .job(job), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data));
endmodule
`default_nettype wire

@@ hdl/lpm_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/lpm_front.sv @@
// Front part: accepts items, classifies them and queues jobs for the walker.
`timescale 1ns / 1ps
`default_nettype none
module lpm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire lpm_pkg::req_type req_data,
   input  wire logic [31:0]      local_address,
   output logic                  job_valid,
   input  wire logic             job_take,
   output lpm_pkg::job_type      job
);
   localparam int unsigned Depth = lpm_pkg::QueueDepth;
   localparam int unsigned AW = $clog2(Depth);

   lpm_pkg::job_type      q_ff [Depth];
   logic [AW-1:0]         wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]           cnt_ff, cnt_in;
   lpm_pkg::job_type      new_job;
   logic                  do_push, do_pop;

   always_comb begin
      new_job.is_insert = ~req_data.func;
      new_job.is_local  = req_data.func && (req_data.packet_dst == local_address);
      new_job.key       = req_data.func ? req_data.packet_dst : req_data.route_prefix;
      new_job.depth     = (req_data.prefix_len > 6'(lpm_pkg::MaxPrefix)) ?
                          6'(lpm_pkg::MaxPrefix) : req_data.prefix_len;
      new_job.hop       = req_data.route_next_hop;
      new_job.ttl       = req_data.packet_ttl;
      new_job.checksum  = req_data.packet_checksum;
   end

   assign full      = (cnt_ff == (AW+1)'(Depth));
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = job_take && job_valid;

   always_comb begin
      wp_in  = do_push ? AW'((wp_ff + 1'b1) % Depth) : wp_ff;
      rp_in  = do_pop ? AW'((rp_ff + 1'b1) % Depth) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wp_ff] <= new_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(Depth))
      else $error("Job queue count overflow.");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("Job queue count lost a push.");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == '0) |-> !job_valid)
      else $error("Empty job queue shows a job.");
endmodule
`default_nettype wire

@@ hdl/lpm_walker.sv @@
// Back part: walks the trie one level per step for inserts and lookups; local deliveries skip the walk.
`timescale 1ns / 1ps
`default_nettype none
module lpm_walker #(
   parameter int unsigned TRIE_NODES = lpm_pkg::TrieNodesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_take,
   input  wire lpm_pkg::job_type job,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output lpm_pkg::rsp_type      rsp_data
);
   localparam int unsigned NW = $clog2(TRIE_NODES);
   localparam int unsigned CW = 2 * NW;
   localparam int unsigned EW = CW + 1;

   lpm_pkg::walk_state_type state_ff, state_in;
   lpm_pkg::job_type        job_ff;
   logic [NW-1:0]   node_ff, node_in;
   logic [5:0]      lvl_ff, lvl_in;
   logic [NW:0]     free_ff, free_in;
   logic            found_ff, found_in;
   logic [31:0]     hop_ff, hop_in;
   logic            dflt_ff, dflt_in;
   logic            full_ff, full_in;
   logic            rsp_valid_ff;
   lpm_pkg::rsp_type rsp_ff, rsp_in;
   logic            rsp_load;

   // The root entry is zero after reset until first written; a fresh node is zero until
   // its entry is written in the step after its allocation.
   logic            root_wr_ff, root_wr_in;
   logic            fresh_ff, fresh_in;

   // Node entry: route-valid flag, then the right and left child indexes.
   logic [EW-1:0]  ch_rd;
   logic           ch_we;
   logic [NW-1:0]  ch_wa, ch_ra;
   logic [EW-1:0]  ch_wd;
   logic [31:0]    nh_rd;
   logic           nh_we;
   logic [NW-1:0]  nh_wa;

   logic           blank;
   logic           cur_valid;
   logic [CW-1:0]  cur_children;
   logic           node_hit;
   logic           bit_sel;
   logic [NW-1:0]  child;
   logic           at_target;
   logic           table_full;
   logic           walk_end;
   logic [7:0]     ttl_dec;

   lpm_ram #(.WIDTH(EW), .DEPTH(TRIE_NODES)) u_children (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
      .rd_addr(ch_ra), .rd_data(ch_rd));

   lpm_ram #(.WIDTH(32), .DEPTH(TRIE_NODES)) u_next_hop (
      .clock(clock), .wr_en(nh_we), .wr_addr(nh_wa), .wr_data(job_ff.hop),
      .rd_addr(ch_ra), .rd_data(nh_rd));

   assign blank        = fresh_ff || (node_ff == '0 && !root_wr_ff);
   assign cur_valid    = blank ? 1'b0 : ch_rd[CW];
   assign cur_children = blank ? '0 : ch_rd[CW-1:0];
   assign node_hit     = (node_ff == '0) ? dflt_ff : cur_valid;
   assign bit_sel      = job_ff.key[5'd31 - lvl_ff[4:0]];
   assign child        = bit_sel ? cur_children[CW-1:NW] : cur_children[NW-1:0];
   assign at_target    = (lvl_ff == job_ff.depth);
   assign table_full   = (free_ff >= (NW+1)'(TRIE_NODES));
   assign walk_end     = (lvl_ff == 6'(lpm_pkg::MaxPrefix)) || (child == '0);
   assign ttl_dec      = job_ff.ttl - 8'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpm_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = job.is_local ? lpm_pkg::ST_DONE : lpm_pkg::ST_WAIT;
            end
         end
         lpm_pkg::ST_WAIT: begin
            state_in = lpm_pkg::ST_STEP;
         end
         lpm_pkg::ST_STEP: begin
            if (job_ff.is_insert) begin
               if (at_target) begin
                  state_in = lpm_pkg::ST_DONE;
               end else if (child != '0) begin
                  state_in = lpm_pkg::ST_WAIT;
               end else if (table_full) begin
                  state_in = lpm_pkg::ST_DONE;
               end else begin
                  state_in = lpm_pkg::ST_STEP;
               end
            end else if (walk_end) begin
               state_in = lpm_pkg::ST_DONE;
            end else begin
               state_in = lpm_pkg::ST_WAIT;
            end
         end
         lpm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               state_in = lpm_pkg::ST_IDLE;
            end
         end
         default: state_in = lpm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      node_in    = node_ff;
      lvl_in     = lvl_ff;
      free_in    = free_ff;
      found_in   = found_ff;
      hop_in     = hop_ff;
      dflt_in    = dflt_ff;
      full_in    = full_ff;
      root_wr_in = root_wr_ff;
      fresh_in   = 1'b0;
      ch_we      = 1'b0;
      ch_wa      = node_ff;
      ch_wd      = {cur_valid, cur_children};
      ch_ra      = node_ff;
      nh_we      = 1'b0;
      nh_wa      = node_ff;
      case (state_ff)
         lpm_pkg::ST_IDLE: begin
            ch_ra = '0;
            if (job_valid) begin
               node_in  = '0;
               lvl_in   = '0;
               found_in = 1'b0;
               full_in  = 1'b0;
            end
         end
         lpm_pkg::ST_WAIT: begin
            if (!job_ff.is_insert && node_hit) begin
               found_in = 1'b1;
               hop_in   = nh_rd;
            end
         end
         lpm_pkg::ST_STEP: begin
            if (job_ff.is_insert) begin
               if (at_target) begin
                  ch_we = 1'b1;
                  ch_wd = {1'b1, cur_children};
                  nh_we = 1'b1;
                  if (job_ff.depth == '0) begin
                     dflt_in = 1'b1;
                  end
               end else if (child != '0) begin
                  node_in = child;
                  ch_ra   = child;
                  lvl_in  = lvl_ff + 6'd1;
               end else if (table_full) begin
                  full_in = 1'b1;
                  if (fresh_ff) begin
                     ch_we = 1'b1;
                     ch_wd = '0;
                  end
               end else begin
                  // New node: link it under the current node; its own entry follows.
                  ch_we = 1'b1;
                  if (bit_sel) begin
                     ch_wd = {cur_valid, free_ff[NW-1:0], cur_children[NW-1:0]};
                  end else begin
                     ch_wd = {cur_valid, cur_children[CW-1:NW], free_ff[NW-1:0]};
                  end
                  fresh_in = 1'b1;
                  node_in  = free_ff[NW-1:0];
                  free_in  = free_ff + 1'b1;
                  lvl_in   = lvl_ff + 6'd1;
               end
            end else if (!walk_end) begin
               node_in = child;
               ch_ra   = child;
               lvl_in  = lvl_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
      if (ch_we && ch_wa == '0) begin
         root_wr_in = 1'b1;
      end
   end

   always_comb begin
      rsp_load = (state_ff == lpm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_pop);
      rsp_in   = '0;
      if (job_ff.is_insert) begin
         rsp_in.action = full_ff ? lpm_pkg::ACT_FULL : lpm_pkg::ACT_ADDED;
      end else if (job_ff.is_local) begin
         rsp_in.action = lpm_pkg::ACT_LOCAL;
      end else if (!found_ff) begin
         rsp_in.action = lpm_pkg::ACT_NO_ROUTE;
      end else if (ttl_dec == '0) begin
         rsp_in.action = lpm_pkg::ACT_TTL_DROP;
      end else begin
         rsp_in.action       = lpm_pkg::ACT_FORWARD;
         rsp_in.next_hop     = hop_ff;
         rsp_in.new_ttl      = ttl_dec;
         rsp_in.new_checksum = lpm_pkg::csum_update(job_ff.checksum, job_ff.ttl, ttl_dec);
      end
   end

   assign job_take  = (state_ff == lpm_pkg::ST_IDLE);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpm_pkg::ST_IDLE;
         free_ff      <= (NW+1)'(1);
         dflt_ff      <= 1'b0;
         root_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         free_ff    <= free_in;
         dflt_ff    <= dflt_in;
         root_wr_ff <= root_wr_in;
         fresh_ff   <= fresh_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == lpm_pkg::ST_IDLE && job_valid) begin
         job_ff <= job;
      end
      node_ff  <= node_in;
      lvl_ff   <= lvl_in;
      found_ff <= found_in;
      hop_ff   <= hop_in;
      full_ff  <= full_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) free_ff <= (NW+1)'(TRIE_NODES))
      else $error("Node allocator ran past the table.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != lpm_pkg::ST_IDLE) |-> lvl_ff <= 6'(lpm_pkg::MaxPrefix))
      else $error("Walk went deeper than 32 levels.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !rsp_empty)
      else $error("Loaded result is not shown.");
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the IPv4 longest-prefix-match forwarding engine.
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned NodeCount = 1024;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   lpm_pkg::req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   lpm_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   ipv4_lpm_forwarding_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the route trie.
   logic [31:0] trie_left [NodeCount];
   logic [31:0] trie_right [NodeCount];
   logic        trie_has_route [NodeCount];
   logic [31:0] trie_hop [NodeCount];
   int unsigned trie_next_free;
   logic        default_seen;
   logic [31:0] router_addr;

   lpm_pkg::req_type pending_items[$];
   lpm_pkg::rsp_type expected_rsps[$];
   int unsigned error_count = 0;
   bit quiet_mode = 1'b0;
   bit hold_rsp = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned take_gap = 0;
   logic req_full_seen;

   logic [31:0] known_prefixes[$];
   logic [5:0]  known_lens[$];

   function automatic logic [31:0] child_node(int unsigned node, logic bit_val);
      logic [31:0] c;
      c = bit_val ? trie_right[node] : trie_left[node];
      return (c < NodeCount) ? c : 0;
   endfunction

   function automatic lpm_pkg::action_type insert_route(logic [31:0] prefix,
                                                        logic [5:0] len_in,
                                                        logic [31:0] hop);
      int unsigned node;
      int unsigned len;
      logic        b;
      logic [31:0] c;
      node = 0;
      len = (len_in > 32) ? 32 : len_in;
      for (int i = 0; i < len; i++) begin
         b = prefix[31 - i];
         c = child_node(node, b);
         if (c == 0) begin
            if (trie_next_free >= NodeCount) return lpm_pkg::ACT_FULL;
            c = trie_next_free;
            trie_next_free++;
            trie_left[c] = 0;
            trie_right[c] = 0;
            trie_has_route[c] = 1'b0;
            if (b) trie_right[node] = c;
            else trie_left[node] = c;
         end
         node = c;
      end
      trie_has_route[node] = 1'b1;
      trie_hop[node] = hop;
      if (len == 0) default_seen = 1'b1;
      return lpm_pkg::ACT_ADDED;
   endfunction

   function automatic lpm_pkg::rsp_type predict_forwarding(lpm_pkg::req_type item);
      lpm_pkg::rsp_type r;
      int unsigned node;
      logic [31:0] c;
      logic        found;
      logic [31:0] hop;
      logic [7:0]  t;
      logic [31:0] s;
      r = '0;
      found = 1'b0;
      hop = 0;
      if (!item.func) begin
         r.action = insert_route(item.route_prefix, item.prefix_len, item.route_next_hop);
         return r;
      end
      if (item.packet_dst == router_addr) begin
         r.action = lpm_pkg::ACT_LOCAL;
         return r;
      end
      if (default_seen && trie_has_route[0]) begin
         found = 1'b1;
         hop = trie_hop[0];
      end
      node = 0;
      for (int i = 0; i < 32; i++) begin
         c = child_node(node, item.packet_dst[31 - i]);
         if (c == 0) break;
         node = c;
         if (trie_has_route[node]) begin
            found = 1'b1;
            hop = trie_hop[node];
         end
      end
      if (!found) begin
         r.action = lpm_pkg::ACT_NO_ROUTE;
         return r;
      end
      t = item.packet_ttl - 8'd1;
      if (t == 0) begin
         r.action = lpm_pkg::ACT_TTL_DROP;
         return r;
      end
      s = {16'd0, ~item.packet_checksum} + {16'd0, ~{item.packet_ttl, 8'h00}}
          + {16'd0, t, 8'h00};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      r.action = lpm_pkg::ACT_FORWARD;
      r.next_hop = hop;
      r.new_ttl = t;
      r.new_checksum = ~s[15:0];
      return r;
   endfunction

   function automatic lpm_pkg::req_type route_item(logic [31:0] prefix, logic [5:0] len,
                                                   logic [31:0] hop);
      lpm_pkg::req_type it;
      it = '0;
      it.func = 1'b0;
      it.route_prefix = prefix;
      it.prefix_len = len;
      it.route_next_hop = hop;
      it.packet_dst = $urandom;
      it.packet_ttl = 8'($urandom);
      it.packet_checksum = 16'($urandom);
      return it;
   endfunction

   function automatic lpm_pkg::req_type packet_item(logic [31:0] dst, logic [7:0] ttl,
                                                    logic [15:0] cks);
      lpm_pkg::req_type it;
      it = '0;
      it.func = 1'b1;
      it.route_prefix = $urandom;
      it.prefix_len = 6'($urandom);
      it.route_next_hop = $urandom;
      it.packet_dst = dst;
      it.packet_ttl = ttl;
      it.packet_checksum = cks;
      return it;
   endfunction

   // Sender: drives one item at a time and predicts it once accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_full_seen) begin
            expected_rsps.push_back(predict_forwarding(req_data));
            void'(pending_items.pop_front());
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            if (!quiet_mode && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 9);
               req_push <= 1'b0;
            end else begin
               req_push <= 1'b1;
               req_data <= pending_items[0];
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_full_seen <= req_full;
   end

   // Receiver: decides pop at the falling edge, checks at the rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(0, 9);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lpm_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.action !== want.action || rsp_data.next_hop !== want.next_hop ||
                rsp_data.new_ttl !== want.new_ttl ||
                rsp_data.new_checksum !== want.new_checksum) begin
               $display("%0t: mismatch, expected %h actual %h", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         if (hold_cycles == 1) hold_rsp <= 1'b0;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_router_addr(logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      router_addr = value;
   endtask

   function automatic logic [31:0] pick_dst();
      int unsigned k;
      logic [31:0] mask;
      if (known_prefixes.size() == 0 || $urandom_range(0, 3) == 0) return $urandom;
      k = $urandom_range(0, known_prefixes.size() - 1);
      mask = (known_lens[k] >= 32) ? 32'hffffffff :
             (known_lens[k] == 0) ? 32'h0 : ~(32'hffffffff >> known_lens[k]);
      return (known_prefixes[k] & mask) | ($urandom & ~mask);
   endfunction

   task automatic add_random_route();
      logic [31:0] p;
      logic [5:0]  l;
      case ($urandom_range(0, 9))
         0: l = 6'($urandom_range(33, 63));
         1: l = 6'd0;
         2, 3: l = 6'($urandom_range(25, 32));
         default: l = 6'($urandom_range(1, 24));
      endcase
      if (known_prefixes.size() > 0 && $urandom_range(0, 3) == 0)
         p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
      else
         p = $urandom;
      known_prefixes.push_back(p);
      known_lens.push_back(l);
      pending_items.push_back(route_item(p, l, $urandom));
   endtask

   task automatic add_random_packet();
      logic [7:0] ttl;
      logic [31:0] dst;
      case ($urandom_range(0, 9))
         0: ttl = 8'd1;
         1: ttl = 8'd0;
         2: ttl = 8'hff;
         default: ttl = 8'($urandom);
      endcase
      dst = ($urandom_range(0, 19) == 0) ? router_addr : pick_dst();
      pending_items.push_back(packet_item(dst, ttl, 16'($urandom)));
   endtask

   initial begin
      for (int i = 0; i < NodeCount; i++) begin
         trie_left[i] = 0;
         trie_right[i] = 0;
         trie_has_route[i] = 1'b0;
         trie_hop[i] = 0;
      end
      trie_next_free = 1;
      default_seen = 1'b0;
      router_addr = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_router_addr(32'h0a000001);

      // Directed: no routes yet, then extremes and special cases.
      pending_items.push_back(packet_item(32'h01020304, 8'd64, 16'h1234));
      pending_items.push_back(packet_item(32'h0a000001, 8'd64, 16'hffff));
      pending_items.push_back(route_item(32'hc0a80000, 6'd16, 32'h0b000001));
      pending_items.push_back(packet_item(32'hc0a80101, 8'd1, 16'h0000));
      pending_items.push_back(packet_item(32'hc0a8ffff, 8'd0, 16'hffff));
      pending_items.push_back(packet_item(32'hc0a80101, 8'd255, 16'h0000));
      pending_items.push_back(route_item(32'hc0a80100, 6'd24, 32'h0));
      pending_items.push_back(packet_item(32'hc0a801ff, 8'd2, 16'h8000));
      pending_items.push_back(route_item(32'hc0a80000, 6'd16, 32'hffffffff));
      pending_items.push_back(packet_item(32'hc0a80201, 8'd10, 16'h00ff));
      pending_items.push_back(route_item(32'hffffffff, 6'd32, 32'h12345678));
      pending_items.push_back(route_item(32'h00000000, 6'd63, 32'h87654321));
      pending_items.push_back(packet_item(32'hffffffff, 8'd128, 16'h7fff));
      pending_items.push_back(packet_item(32'h00000000, 8'd33, 16'haaaa));
      pending_items.push_back(packet_item(32'h55555555, 8'd5, 16'h5555));
      pending_items.push_back(route_item(32'habcdef01, 6'd0, 32'hdeadbeef));
      pending_items.push_back(packet_item(32'h55555555, 8'd5, 16'h5555));
      pending_items.push_back(route_item(32'hc0a80000, 6'd17, 32'h01010101));
      pending_items.push_back(packet_item(32'hc0a87fff, 8'd200, 16'h0001));
      wait_drained();

      write_router_addr(32'hffffffff);
      for (int n = 0; n < 500; n++) begin
         if ($urandom_range(0, 2) == 0) add_random_route();
         else add_random_packet();
      end
      // Hold the receiver off so the block fills and stalls its input.
      hold_rsp = 1'b1;
      hold_cycles = 600;
      wait_drained();

      write_router_addr(32'h00000000);
      for (int n = 0; n < 500; n++) begin
         if ($urandom_range(0, 3) == 0) add_random_route();
         else add_random_packet();
      end
      wait_drained();

      // Table exhaustion with long random prefixes, all in quiet mode.
      write_router_addr($urandom);
      quiet_mode = 1'b1;
      for (int n = 0; n < 250; n++) begin
         if ($urandom_range(0, 1) == 0)
            pending_items.push_back(route_item($urandom, 6'd32, $urandom));
         else
            add_random_packet();
      end
      wait_drained();

      if (error_count == 0) begin
         $display("ipv4_lpm_forwarding_engine_unit regression: pass");
      end else begin
         $display("ipv4_lpm_forwarding_engine_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("ipv4_lpm_forwarding_engine_unit regression: fail");
      $finish;
   end
endmodule
